// File: sv/gerode_pkg.sv
// ----------------------------------------------------------------------------
// Grayscale erosion package
// Shared types and constants for the masked 3x3 grayscale erosion block.
// ----------------------------------------------------------------------------
package gerode_pkg;

	localparam int PIX_W        = 8;
	localparam int MASK_W       = 8;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 16;
	localparam int CFG_IDX_W    = 4;
	localparam int CFG_DATA_W   = 16;
	localparam int FIFO_DEPTH   = 3;

	typedef logic [PIX_W-1:0]      pix_t;
	typedef logic [8:0][PIX_W-1:0] win_t;
	typedef logic [3:0]            tap_t;

	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} border_t;

	localparam logic [CFG_IDX_W-1:0] REG_MASK   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 4'd2;

	localparam logic [MASK_W-1:0]       MASK_RESET   = 8'hFF;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd1;

	localparam logic FUNC_DRAIN = 1'b1;

	// Window taps are numbered row by row from the north-west corner.
	localparam tap_t CENTRE_TAP = 4'd4;
	localparam tap_t DIR_TAP [8] = '{4'd5, 4'd2, 4'd1, 4'd0, 4'd3, 4'd6, 4'd7, 4'd8};

	localparam logic [MASK_W-1:0] DIRS_NORTH = 8'b0000_1110;
	localparam logic [MASK_W-1:0] DIRS_SOUTH = 8'b1110_0000;
	localparam logic [MASK_W-1:0] DIRS_WEST  = 8'b0011_1000;
	localparam logic [MASK_W-1:0] DIRS_EAST  = 8'b1000_0011;

endpackage

// File: sv/gray_erosion_3x3_masked.sv
// ----------------------------------------------------------------------------
// Masked 3x3 grayscale erosion
// Streaming erosion filter with two line stores held in one on-chip memory.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock and gives one result per clock
// once the pipeline is full and no stall is raised; a window's last pixel
// is registered in s1 and its result in the output queue. Results lag the
// pixel stream by image_width + 1 positions, so image_width + 1 drain
// transactions must follow the last pixel of an image. The two rows above
// the current one sit side by side in a single MAX_WIDTH-entry memory, read
// when a transaction is taken and written back in the next cycle; when two
// consecutive transactions use the same column, as in a one-pixel-wide
// image or at the first pixel after an image ends, the write-back is
// forwarded to the following read. Memory contents are not cleared, since
// a line store entry from before the first row only ever feeds a neighbour
// outside the image. A three-entry output queue decouples the two channels.
// ----------------------------------------------------------------------------
module gray_erosion_3x3_masked #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic [gerode_pkg::PIX_W-1:0]        pixel_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [gerode_pkg::PIX_W-1:0]        eroded_value,
	output logic                                end_of_image,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gerode_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gerode_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import gerode_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_W) ?
	                     $clog2(MAX_WIDTH + 1) : WIDTH_REG_W;
	localparam int RW  = HEIGHT_REG_W + 1;
	localparam int MDW = 2 * PIX_W;

	logic [MASK_W-1:0]       mask_q;
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [CW-1:0]           col_q;
	logic [RW-1:0]           row_q;

	logic [WW-1:0]           w_ext;
	logic [WW-1:0]           w_eff;
	logic [HEIGHT_REG_W-1:0] h_eff;
	logic [RW-1:0]           h_ext;
	logic [CW-1:0]           c_eff;
	logic                    in_image;
	logic                    accept;
	logic                    step;
	logic                    col_first;
	logic                    col_last;
	logic                    produces;
	logic                    last_res;
	logic                    restart;
	border_t                 border;

	logic [MDW-1:0]          line_mem [MAX_WIDTH];
	logic [MDW-1:0]          mem_rd_q;

	logic                    valid_s1;
	logic                    res_s1;
	logic                    old_s1;
	logic                    eoi_s1;
	logic                    fwd_s1;
	logic [CW-1:0]           addr_s1;
	pix_t                    pix_s1;
	border_t                 border_s1;
	logic [MDW-1:0]          fwd_data_s1;

	win_t                    win_q;
	win_t                    win_next;
	win_t                    win_eval;
	pix_t                    upper_rd;
	pix_t                    lower_rd;
	pix_t                    eroded;
	logic [MDW-1:0]          wr_data;

	pix_t                    fifo_pix_q [FIFO_DEPTH];
	logic                    fifo_eoi_q [FIFO_DEPTH];
	logic [1:0]              wr_ptr_q;
	logic [1:0]              rd_ptr_q;
	logic [1:0]              cnt_q;
	logic                    push;
	logic                    pop;
	logic [2:0]              occupancy;

	// Effective image size and the position of the incoming transaction.
	assign w_ext  = WW'(width_q);
	assign w_eff  = (width_q == '0) ? WW'(1) :
	                (w_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_ext;
	assign h_eff  = (height_q == '0) ? HEIGHT_REG_W'(1) : height_q;
	assign h_ext  = RW'(h_eff);
	assign c_eff  = (WW'(col_q) >= w_eff) ? '0 : col_q;
	assign in_image = row_q < h_ext;

	assign accept    = in_valid & ~in_stall;
	assign step      = accept & ~(in_image & (func == FUNC_DRAIN));
	assign col_first = (c_eff == '0);
	assign col_last  = (WW'(c_eff) + WW'(1)) >= w_eff;
	assign produces  = (row_q != '0) && (!col_first || (row_q >= RW'(2)));
	assign last_res  = col_first && (row_q == (h_ext + RW'(1)));

	assign border.top    = col_first ? (row_q == RW'(2)) : (row_q == RW'(1));
	assign border.bottom = col_first ? (row_q == (h_ext + RW'(1))) : (row_q == h_ext);
	assign border.left   = col_first ? (w_eff == WW'(1)) : (c_eff == CW'(1));
	assign border.right  = col_first;

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= MASK_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MASK:   mask_q   <= cfg_data[MASK_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (last_res) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_last) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= c_eff + CW'(1);
			end
		end
	end

	// Line stores: each entry holds the upper row above the lower row.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_mem[addr_s1] <= wr_data;
		end
		if (step) begin
			mem_rd_q <= line_mem[c_eff];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_s1   <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= step;
			res_s1   <= step & produces;
			fwd_s1   <= valid_s1 && (addr_s1 == c_eff);
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			addr_s1     <= c_eff;
			pix_s1      <= in_image ? pixel_value : '0;
			old_s1      <= col_first;
			eoi_s1      <= last_res;
			border_s1   <= border;
			fwd_data_s1 <= wr_data;
		end
	end

	assign {upper_rd, lower_rd} = fwd_s1 ? fwd_data_s1 : mem_rd_q;
	assign wr_data              = {lower_rd, pix_s1};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_next[i*3+0] = win_q[i*3+1];
			win_next[i*3+1] = win_q[i*3+2];
			win_eval[i*3+0] = win_q[i*3+1];
			win_eval[i*3+1] = win_q[i*3+2];
			win_eval[i*3+2] = '0;
		end
		win_next[2] = upper_rd;
		win_next[5] = lower_rd;
		win_next[8] = pix_s1;
		if (!old_s1) begin
			win_eval = win_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (valid_s1) begin
			win_q <= win_next;
		end
	end

	gerode_kernel u_kernel (
		.window (win_eval),
		.mask   (mask_q),
		.border (border_s1),
		.eroded (eroded)
	);

	// Output queue.
	assign push      = valid_s1 & res_s1;
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid & ~out_stall;
	assign occupancy = {1'b0, cnt_q} + {2'b00, push};
	assign in_stall  = occupancy >= 3'(FIFO_DEPTH);

	assign eroded_value = fifo_pix_q[rd_ptr_q];
	assign end_of_image = fifo_eoi_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_pix_q[wr_ptr_q] <= eroded;
			fifo_eoi_q[wr_ptr_q] <= eoi_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			cnt_q <= 2'(occupancy - {2'b00, pop});
		end
	end

endmodule

// File: sv/gerode_kernel.sv
// ----------------------------------------------------------------------------
// Erosion kernel
// Minimum over the centre tap and the enabled neighbours of a 3x3 window,
// forced to zero when an enabled neighbour falls outside the image.
// ----------------------------------------------------------------------------
module gerode_kernel (
	input  gerode_pkg::win_t              window,
	input  logic [gerode_pkg::MASK_W-1:0] mask,
	input  gerode_pkg::border_t           border,
	output gerode_pkg::pix_t              eroded
);
	import gerode_pkg::*;

	logic [MASK_W-1:0] blocked;
	pix_t              min_val;

	assign blocked = mask & (({MASK_W{border.top}}    & DIRS_NORTH) |
	                         ({MASK_W{border.bottom}} & DIRS_SOUTH) |
	                         ({MASK_W{border.left}}   & DIRS_WEST)  |
	                         ({MASK_W{border.right}}  & DIRS_EAST));

	always_comb begin
		min_val = window[CENTRE_TAP];
		for (int k = 0; k < MASK_W; k++) begin
			if (mask[k] && (window[DIR_TAP[k]] < min_val)) begin
				min_val = window[DIR_TAP[k]];
			end
		end
	end

	assign eroded = (|blocked) ? '0 : min_val;

endmodule

// File: sv/gerode_checker.sv
// ----------------------------------------------------------------------------
// Erosion port checker
// Temporal checks on the ports of the masked 3x3 grayscale erosion block.
// ----------------------------------------------------------------------------
module gerode_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [gerode_pkg::PIX_W-1:0]      eroded_value,
	input logic                              end_of_image,
	input logic                              cfg_valid,
	input logic                              cfg_ready
);
	import gerode_pkg::*;

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(eroded_value) &&
		$stable(end_of_image))
		else $error("result changed while stalled");

	// Each new result follows an input taken into s1 and then the queue.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without a preceding input");

	// With no result waiting, the input side is never held off.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output queue");

	// Configuration writes are always taken.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind gray_erosion_3x3_masked gerode_checker u_gerode_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.eroded_value (eroded_value),
	.end_of_image (end_of_image),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

// File: tb/gray_erosion_3x3_masked_test.sv
// ----------------------------------------------------------------------------
// Masked 3x3 grayscale erosion testbench
// Streams images through the block and checks every eroded pixel against a
// behavioural model of the filter kept inside this testbench. Input bursts,
// output stalls and register writes between images vary at random.
// ----------------------------------------------------------------------------
module gray_erosion_3x3_masked_test;
	import gerode_pkg::*;

	localparam int MAX_W        = 1024;
	localparam int SETTLE       = 12;
	localparam int RANDOM_ITEMS = 200;
	localparam int LIMIT        = 2000000;

	typedef struct packed {
		pix_t value;
		logic last;
	} erosion_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic                  func         = 1'b0;
	pix_t                  pixel_value  = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	pix_t                  eroded_value;
	logic                  end_of_image;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	pix_t                    upper_line [MAX_W];
	pix_t                    lower_line [MAX_W];
	pix_t                    window [9];
	int unsigned             in_col;
	int unsigned             in_row;
	logic [MASK_W-1:0]       mask_reg;
	logic [WIDTH_REG_W-1:0]  width_reg;
	logic [HEIGHT_REG_W-1:0] height_reg;

	erosion_t pending_erosions [$];
	int       mismatches   = 0;
	int       useful_items = 0;
	int       burst_left   = 0;
	int       stall_mode   = 0;
	int       stall_left   = 0;

	gray_erosion_3x3_masked #(
		.MAX_WIDTH(MAX_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.pixel_value(pixel_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.eroded_value(eroded_value),
		.end_of_image(end_of_image),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial forever #1 clk = ~clk;

	initial begin
		#LIMIT;
		$display("gray_erosion_3x3_masked test failed");
		$finish;
	end

	function automatic int unsigned active_width();
		if (width_reg == '0)
			return 1;
		if (width_reg > MAX_W)
			return MAX_W;
		return width_reg;
	endfunction

	function automatic int unsigned active_height();
		return (height_reg == '0) ? 1 : height_reg;
	endfunction

	function automatic int row_step(input int k);
		case (k)
			0, 4:    return 0;
			1, 2, 3: return -1;
			default: return 1;
		endcase
	endfunction

	function automatic int col_step(input int k);
		case (k)
			0, 1, 7: return 1;
			2, 6:    return 0;
			default: return -1;
		endcase
	endfunction

	function automatic pix_t any_pixel();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_height();
		if (active_width() > 40)
			return $urandom_range(0, 2);
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return $urandom_range(7, 16);
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Works out the result, if any, of one accepted transaction.
	task automatic erode_step(input logic f, input pix_t p);
		int unsigned w, h, r, c, orow, ocol;
		int          nr, nc;
		pix_t        px, low;
		pix_t        v [9];
		bit          outside;
		erosion_t    res;
		w = active_width();
		h = active_height();
		r = in_row;
		c = in_col;
		px = '0;
		outside = 1'b0;
		if (r < h) begin
			if (f == FUNC_DRAIN)
				return;
			px = p;
		end
		useful_items++;
		if (c >= w)
			c = 0;
		if (c == 0) begin
			for (int i = 0; i < 3; i++) begin
				v[i * 3]     = window[i * 3 + 1];
				v[i * 3 + 1] = window[i * 3 + 2];
				v[i * 3 + 2] = '0;
			end
		end
		for (int i = 0; i < 3; i++) begin
			window[i * 3]     = window[i * 3 + 1];
			window[i * 3 + 1] = window[i * 3 + 2];
		end
		window[2] = upper_line[c];
		window[5] = lower_line[c];
		window[8] = px;
		upper_line[c] = lower_line[c];
		lower_line[c] = px;
		if (c != 0)
			v = window;
		if (c + 1 >= w) begin
			in_col = 0;
			in_row = r + 1;
		end else begin
			in_col = c + 1;
		end
		if (r == 0 || (c == 0 && r < 2))
			return;
		if (c >= 1) begin
			orow = r - 1;
			ocol = c - 1;
		end else begin
			orow = r - 2;
			ocol = w - 1;
		end
		low = v[4];
		for (int k = 0; k < 8; k++) begin
			if (mask_reg[k]) begin
				nr = int'(orow) + row_step(k);
				nc = int'(ocol) + col_step(k);
				if (nr < 0 || nr >= int'(h) || nc < 0 || nc >= int'(w))
					outside = 1'b1;
				else if (v[(1 + row_step(k)) * 3 + 1 + col_step(k)] < low)
					low = v[(1 + row_step(k)) * 3 + 1 + col_step(k)];
			end
		end
		res.value = outside ? '0 : low;
		res.last = (orow == h - 1 && ocol == w - 1);
		pending_erosions.push_back(res);
		if (res.last) begin
			in_row = 0;
			in_col = 0;
		end
	endtask

	always @(posedge clk) begin : check_output
		erosion_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_erosions.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", eroded_value));
			end else begin
				want = pending_erosions.pop_front();
				if (eroded_value !== want.value)
					report_mismatch($sformatf("eroded_value %0d, expected %0d",
						eroded_value, want.value));
				if (end_of_image !== want.last)
					report_mismatch($sformatf("end_of_image %b, expected %b",
						end_of_image, want.last));
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 300);
		end
		stall_left--;
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= $urandom_range(0, 1);
			2:       out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((stall_left % 5) < 2);
		endcase
	end

	task automatic push_item(input logic f, input pix_t p);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		func <= f;
		pixel_value <= p;
		do @(posedge clk); while (in_stall);
		erode_step(f, p);
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_erosions.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MASK:
				mask_reg = data[MASK_W-1:0];
			REG_WIDTH: begin
				width_reg = data[WIDTH_REG_W-1:0];
				in_row = 0;
				in_col = 0;
			end
			REG_HEIGHT: begin
				height_reg = data[HEIGHT_REG_W-1:0];
				in_row = 0;
				in_col = 0;
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_shape(input logic [MASK_W-1:0] m, input int unsigned w,
		input int unsigned h);
		wait_quiet();
		write_reg(REG_MASK, CFG_DATA_W'(m));
		write_reg(REG_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_HEIGHT, CFG_DATA_W'(h));
	endtask

	// Sends one whole image from its first pixel, then drain transactions
	// until the last result of the image has been predicted.
	task automatic send_image(input int stray_pct);
		int unsigned count;
		count = active_width() * active_height();
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < stray_pct)
				push_item(FUNC_DRAIN, any_pixel());
			if ($urandom_range(0, 299) == 0)
				wait_quiet();
			push_item(!FUNC_DRAIN, any_pixel());
		end
		do
			push_item(($urandom_range(0, 99) < stray_pct) ? !FUNC_DRAIN : FUNC_DRAIN,
				any_pixel());
		while (in_row != 0 || in_col != 0);
	endtask

	// A full row at the reset shape, then the first few results of it; the
	// pixels past the row act as drain transactions.
	task automatic test_reset_defaults();
		repeat (MAX_W + 4) push_item(!FUNC_DRAIN, any_pixel());
		wait_quiet();
	endtask

	task automatic test_tiny_images();
		set_shape('0, 0, 0);
		send_image(0);
		wait_quiet();
		write_reg(REG_MASK, CFG_DATA_W'(MASK_RESET));
		send_image(0);
		set_shape(DIRS_NORTH | DIRS_SOUTH, 1, 3);
		send_image(0);
		set_shape(~(DIRS_NORTH | DIRS_SOUTH), 3, 1);
		send_image(0);
	endtask

	task automatic test_each_direction();
		for (int k = 0; k < MASK_W; k++) begin
			set_shape(MASK_W'(1) << k, 3, 3);
			send_image(0);
		end
	endtask

	task automatic test_stray_transactions();
		set_shape(MASK_W'($urandom), 4, 3);
		send_image(40);
	endtask

	task automatic test_restart_mid_image();
		logic [CFG_IDX_W-1:0] spare;
		set_shape('0, 5, {HEIGHT_REG_W{1'b1}});
		repeat (12) push_item(!FUNC_DRAIN, any_pixel());
		wait_quiet();
		write_reg(REG_MASK, {8'hA5, MASK_RESET});
		repeat (5) push_item(!FUNC_DRAIN, any_pixel());
		wait_quiet();
		spare = CFG_IDX_W'($urandom_range(REG_HEIGHT + 1, (1 << CFG_IDX_W) - 1));
		write_reg(spare, CFG_DATA_W'($urandom));
		write_reg(REG_HEIGHT, CFG_DATA_W'(2));
		send_image(10);
	endtask

	// An oversized width register acts as the full line store width.
	task automatic test_wide_rows();
		set_shape(~(DIRS_NORTH | DIRS_SOUTH), {WIDTH_REG_W{1'b1}}, 1);
		repeat (MAX_W + 4) push_item(!FUNC_DRAIN, any_pixel());
		wait_quiet();
		write_reg(REG_HEIGHT, CFG_DATA_W'(1));
	endtask

	task automatic test_random_images();
		int                    start;
		int unsigned           w, count;
		logic [CFG_DATA_W-1:0] d;
		start = useful_items;
		while (useful_items - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 4) begin
				wait_quiet();
				if ($urandom_range(0, 1))
					write_reg(REG_MASK, CFG_DATA_W'($urandom));
				if ($urandom_range(0, 1)) begin
					case ($urandom_range(0, 19))
						0:       w = 0;
						1, 2:    w = $urandom_range(9, 40);
						3:       w = $urandom_range(41, 200);
						default: w = $urandom_range(1, 8);
					endcase
					d = CFG_DATA_W'($urandom);
					d[WIDTH_REG_W-1:0] = WIDTH_REG_W'(w);
					write_reg(REG_WIDTH, d);
					write_reg(REG_HEIGHT, CFG_DATA_W'(pick_height()));
				end
			end
			count = active_width() * active_height();
			if ($urandom_range(0, 19) == 0 && count > 1) begin
				repeat ($urandom_range(1, count - 1))
					push_item(!FUNC_DRAIN, any_pixel());
				wait_quiet();
				write_reg(REG_HEIGHT, CFG_DATA_W'(pick_height()));
			end
			send_image($urandom_range(0, 1) ? 0 : 15);
		end
	endtask

	initial begin
		for (int i = 0; i < MAX_W; i++) begin
			upper_line[i] = '0;
			lower_line[i] = '0;
		end
		for (int i = 0; i < 9; i++)
			window[i] = '0;
		in_row = 0;
		in_col = 0;
		mask_reg = MASK_RESET;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_tiny_images();
		test_each_direction();
		test_stray_transactions();
		test_restart_mid_image();
		test_wide_rows();
		test_random_images();
		wait_quiet();
		if (mismatches == 0)
			$display("gray_erosion_3x3_masked test passed");
		else
			$display("gray_erosion_3x3_masked test failed");
		$finish;
	end

endmodule

// File: sim.f
sv/gerode_pkg.sv
sv/gerode_kernel.sv
sv/gray_erosion_3x3_masked.sv
sv/gerode_checker.sv
tb/gray_erosion_3x3_masked_test.sv
